>>> rtl/circle_pair_contact_manifold_macros.svh
// ----------------------------------------------------------------------------
// Circle pair contact manifold assertion macros
// Shared helpers for the concurrent checks on the block's ports.
// ----------------------------------------------------------------------------
`ifndef CIRCLE_PAIR_CONTACT_MANIFOLD_MACROS_SVH
`define CIRCLE_PAIR_CONTACT_MANIFOLD_MACROS_SVH

// Implication checked on every clock edge out of reset.
`define CPCM_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("contact manifold check failed");

// Implication checked in the cycle after the antecedent.
`define CPCM_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("contact manifold check failed");

`endif

>>> rtl/cpcm_pkg.sv
// ----------------------------------------------------------------------------
// Circle pair contact manifold package
// Word types, fixed widths and shared helpers of the contact manifold block.
// ----------------------------------------------------------------------------
package cpcm_pkg;

  localparam int CW   = 24;           // coordinate width, Q15.8
  localparam int RW   = CW - 2;       // radius width
  localparam int SW   = RW + 1;       // radius sum width
  localparam int NW   = 16;           // normal width, Q1.14
  localparam int NFB  = 14;           // normal fraction bits
  localparam int DW   = SW;           // distance width (distance below radius sum)
  localparam int RADW = 2 * DW;       // square root radicand width
  localparam int REMW = DW + 2;       // square root remainder width
  localparam int QW   = NFB + 1;      // normal magnitude width
  localparam int NUMW = DW + NFB;     // dividend width

  typedef struct packed {
    logic signed [CW-1:0] first_x;
    logic signed [CW-1:0] first_y;
    logic signed [CW-1:0] second_x;
    logic signed [CW-1:0] second_y;
    logic [RW-1:0]        first_radius;
    logic [RW-1:0]        second_radius;
  } in_t;

  typedef struct packed {
    logic                 hit;
    logic signed [NW-1:0] normal_x;
    logic signed [NW-1:0] normal_y;
    logic signed [CW-1:0] overlap_x;
    logic signed [CW-1:0] overlap_y;
    logic signed [CW-1:0] contact_x;
    logic signed [CW-1:0] contact_y;
  } out_t;

  // Per-pair data that rides along the cell chain unchanged.
  typedef struct packed {
    logic                 hit;
    logic                 sx;
    logic                 sy;
    logic [DW-1:0]        mx;
    logic [DW-1:0]        my;
    logic [SW-1:0]        s;
    logic [RW-1:0]        ra;
    logic signed [CW-1:0] ax;
    logic signed [CW-1:0] ay;
  } side_t;

  typedef struct packed {
    logic [RADW-1:0] rad;
    logic [REMW-1:0] rem;
    logic [DW-1:0]   root;
  } sqrt_t;

  typedef struct packed {
    logic [DW-1:0]   divisor;
    logic [NUMW-1:0] rx;
    logic [NUMW-1:0] ry;
    logic [QW-1:0]   qx;
    logic [QW-1:0]   qy;
  } div_t;

  function automatic logic signed [CW-1:0] sat_coord(input logic signed [CW+1:0] v);
    logic signed [CW+1:0] hi;
    logic signed [CW+1:0] lo;
    hi = (CW+2)'({1'b0, {(CW-1){1'b1}}});
    lo = -(CW+2)'({1'b1, {(CW-1){1'b0}}});
    if (v > hi) return hi[CW-1:0];
    if (v < lo) return lo[CW-1:0];
    return v[CW-1:0];
  endfunction

endpackage

>>> rtl/cpcm_sqrt_cell.sv
// ----------------------------------------------------------------------------
// Square root cell
// Resolves one root bit of the floored square root and passes the word on.
// ----------------------------------------------------------------------------
module cpcm_sqrt_cell (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            adv,
  input  logic            in_vld,
  input  cpcm_pkg::sqrt_t in_sq,
  input  cpcm_pkg::side_t in_side,
  output logic            out_vld,
  output cpcm_pkg::sqrt_t out_sq,
  output cpcm_pkg::side_t out_side
);
  import cpcm_pkg::*;

  logic [REMW+1:0] rem_sh;
  logic [REMW+1:0] trial;
  logic            take;
  sqrt_t           sq_nxt;
  logic            vld_r;
  sqrt_t           sq_r;
  side_t           side_r;

  // Bring down the next two radicand bits and try root*4+1.
  always_comb begin
    rem_sh      = {in_sq.rem, in_sq.rad[RADW-1 -: 2]};
    trial       = (REMW+2)'({in_sq.root, 2'b01});
    take        = rem_sh >= trial;
    sq_nxt.rad  = {in_sq.rad[RADW-3:0], 2'b00};
    sq_nxt.rem  = take ? REMW'(rem_sh - trial) : rem_sh[REMW-1:0];
    sq_nxt.root = {in_sq.root[DW-2:0], take};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (adv) begin
      vld_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sq_r   <= sq_nxt;
      side_r <= in_side;
    end
  end

  assign out_vld  = vld_r;
  assign out_sq   = sq_r;
  assign out_side = side_r;
endmodule

>>> rtl/cpcm_div_cell.sv
// ----------------------------------------------------------------------------
// Division cell
// Resolves one quotient bit of both normal components by restoring division.
// ----------------------------------------------------------------------------
module cpcm_div_cell #(
  parameter int SHIFT = 14
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            adv,
  input  logic            in_vld,
  input  cpcm_pkg::div_t  in_dv,
  input  cpcm_pkg::side_t in_side,
  output logic            out_vld,
  output cpcm_pkg::div_t  out_dv,
  output cpcm_pkg::side_t out_side
);
  import cpcm_pkg::*;

  logic [NUMW:0] dsh;
  logic          gex;
  logic          gey;
  div_t          dv_nxt;
  logic          vld_r;
  div_t          dv_r;
  side_t         side_r;

  always_comb begin
    dsh            = (NUMW+1)'(in_dv.divisor) << SHIFT;
    gex            = {1'b0, in_dv.rx} >= dsh;
    gey            = {1'b0, in_dv.ry} >= dsh;
    dv_nxt.divisor = in_dv.divisor;
    dv_nxt.rx      = gex ? (in_dv.rx - dsh[NUMW-1:0]) : in_dv.rx;
    dv_nxt.ry      = gey ? (in_dv.ry - dsh[NUMW-1:0]) : in_dv.ry;
    dv_nxt.qx      = {in_dv.qx[QW-2:0], gex};
    dv_nxt.qy      = {in_dv.qy[QW-2:0], gey};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (adv) begin
      vld_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dv_r   <= dv_nxt;
      side_r <= in_side;
    end
  end

  assign out_vld  = vld_r;
  assign out_dv   = dv_r;
  assign out_side = side_r;
endmodule

>>> rtl/circle_pair_contact_manifold.sv
// ----------------------------------------------------------------------------
// Circle pair contact manifold
// Overlap test, unit normal, penetration and contact point for two circles.
// ----------------------------------------------------------------------------
// The block takes one circle pair per word on the in_ channel and returns one
// contact word per pair on the out_ channel, in order. Both channels use
// valid and stall; a word moves on a clock edge with valid high and stall low.
// Every pair gets a result. When the circles do not overlap (touching counts
// as no overlap) hit is 0 and all other fields are 0.
// The datapath is a fixed pipeline of 43 registers. The depth is set by the
// root, a row of 23 cells that each settle one root bit, and the divider, a
// row of 15 cells that each settle one normal bit for x and y together.
// One pair is taken every cycle while the output side keeps taking words.
// When out_stall holds a waiting result, the whole chain freezes and in_stall
// rises in the same cycle; it falls as soon as the output word is taken.
// Reset (rst_n low, synchronous) clears all valid flags; in-flight pairs are
// dropped and the block is ready in the first cycle after reset.
// ----------------------------------------------------------------------------
module circle_pair_contact_manifold (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_stall,
  input  cpcm_pkg::in_t  in_data,
  output logic           out_valid,
  input  logic           out_stall,
  output cpcm_pkg::out_t out_data
);
  import cpcm_pkg::*;

  // The chain moves unless a finished word is held at the output.
  logic adv;
  assign adv      = !(out_valid && out_stall);
  assign in_stall = !adv;

  // Stage 1: centre differences and their magnitudes.
  logic signed [CW:0] dx;
  logic signed [CW:0] dy;
  logic               s1_vld_r;
  logic [CW:0]        s1_mx_r;
  logic [CW:0]        s1_my_r;
  logic               s1_sx_r;
  logic               s1_sy_r;
  logic [SW-1:0]      s1_s_r;
  logic [RW-1:0]      s1_ra_r;
  logic signed [CW-1:0] s1_ax_r;
  logic signed [CW-1:0] s1_ay_r;

  assign dx = (CW+1)'(in_data.second_x) - (CW+1)'(in_data.first_x);
  assign dy = (CW+1)'(in_data.second_y) - (CW+1)'(in_data.first_y);

  // Stage 2: squares.
  logic               s2_vld_r;
  logic [2*CW+1:0]    s2_sqx_r;
  logic [2*CW+1:0]    s2_sqy_r;
  logic [2*SW-1:0]    s2_ss_r;
  side_t              s2_side_r;

  // Stage 3: overlap test, radicand only for hits.
  logic [2*CW+2:0]    d2;
  logic               hit3;
  side_t              s3_side_nxt;
  logic               s3_vld_r;
  sqrt_t              s3_sq_r;
  side_t              s3_side_r;

  assign d2   = (2*CW+3)'(s2_sqx_r) + (2*CW+3)'(s2_sqy_r);
  assign hit3 = d2 < (2*CW+3)'(s2_ss_r);

  always_comb begin
    s3_side_nxt     = s2_side_r;
    s3_side_nxt.hit = hit3;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
      s3_vld_r <= 1'b0;
    end else if (adv) begin
      s1_vld_r <= in_valid;
      s2_vld_r <= s1_vld_r;
      s3_vld_r <= s2_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_mx_r  <= dx[CW] ? (CW+1)'(-dx) : (CW+1)'(dx);
      s1_my_r  <= dy[CW] ? (CW+1)'(-dy) : (CW+1)'(dy);
      s1_sx_r  <= dx[CW];
      s1_sy_r  <= dy[CW];
      s1_s_r   <= SW'(in_data.first_radius) + SW'(in_data.second_radius);
      s1_ra_r  <= in_data.first_radius;
      s1_ax_r  <= in_data.first_x;
      s1_ay_r  <= in_data.first_y;

      s2_sqx_r       <= s1_mx_r * s1_mx_r;
      s2_sqy_r       <= s1_my_r * s1_my_r;
      s2_ss_r        <= s1_s_r * s1_s_r;
      s2_side_r.hit  <= 1'b0;
      s2_side_r.sx   <= s1_sx_r;
      s2_side_r.sy   <= s1_sy_r;
      s2_side_r.mx   <= s1_mx_r[DW-1:0];
      s2_side_r.my   <= s1_my_r[DW-1:0];
      s2_side_r.s    <= s1_s_r;
      s2_side_r.ra   <= s1_ra_r;
      s2_side_r.ax   <= s1_ax_r;
      s2_side_r.ay   <= s1_ay_r;

      s3_sq_r.rad   <= hit3 ? d2[RADW-1:0] : '0;
      s3_sq_r.rem   <= '0;
      s3_sq_r.root  <= '0;
      s3_side_r     <= s3_side_nxt;
    end
  end

  // Square root chain: one root bit per cell, most significant first.
  logic  sq_vld  [DW+1];
  sqrt_t sq_word [DW+1];
  side_t sq_side [DW+1];

  assign sq_vld[0]  = s3_vld_r;
  assign sq_word[0] = s3_sq_r;
  assign sq_side[0] = s3_side_r;

  for (genvar k = 0; k < DW; k++) begin : g_sqrt
    cpcm_sqrt_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .adv      (adv),
      .in_vld   (sq_vld[k]),
      .in_sq    (sq_word[k]),
      .in_side  (sq_side[k]),
      .out_vld  (sq_vld[k+1]),
      .out_sq   (sq_word[k+1]),
      .out_side (sq_side[k+1])
    );
  end

  // Divider chain: the magnitudes never exceed the distance, so the quotient
  // stays at or below one and fits in NFB+1 bits.
  logic  dv_vld  [QW+1];
  div_t  dv_word [QW+1];
  side_t dv_side [QW+1];

  assign dv_vld[0]  = sq_vld[DW];
  assign dv_side[0] = sq_side[DW];
  assign dv_word[0] = '{divisor: sq_word[DW].root,
                        rx:      {sq_side[DW].mx, {NFB{1'b0}}},
                        ry:      {sq_side[DW].my, {NFB{1'b0}}},
                        qx:      '0,
                        qy:      '0};

  for (genvar k = 0; k < QW; k++) begin : g_div
    cpcm_div_cell #(
      .SHIFT (QW - 1 - k)
    ) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .adv      (adv),
      .in_vld   (dv_vld[k]),
      .in_dv    (dv_word[k]),
      .in_side  (dv_side[k]),
      .out_vld  (dv_vld[k+1]),
      .out_dv   (dv_word[k+1]),
      .out_side (dv_side[k+1])
    );
  end

  // Scaling stage. Coincident centres take the fixed normal (1, 0), a
  // penetration of the first radius and a contact at the first centre.
  div_t          dv_end;
  side_t         sd_end;
  logic          zero_d;
  logic [DW-1:0] pen_m;
  logic [RW-1:0] con_m;
  logic [QW-1:0] nmx;
  logic [QW-1:0] nmy;

  assign dv_end = dv_word[QW];
  assign sd_end = dv_side[QW];
  assign zero_d = dv_end.divisor == '0;
  assign pen_m  = zero_d ? DW'(sd_end.ra) : DW'(sd_end.s - dv_end.divisor);
  assign con_m  = zero_d ? '0 : sd_end.ra;
  assign nmx    = zero_d ? QW'(1 << NFB) : dv_end.qx;
  assign nmy    = zero_d ? '0 : dv_end.qy;

  logic                 m_vld_r;
  logic                 m_hit_r;
  logic                 m_sx_r;
  logic                 m_sy_r;
  logic [QW-1:0]        m_nx_r;
  logic [QW-1:0]        m_ny_r;
  logic [DW+QW-1:0]     m_px_r;
  logic [DW+QW-1:0]     m_py_r;
  logic [RW+QW-1:0]     m_cx_r;
  logic [RW+QW-1:0]     m_cy_r;
  logic signed [CW-1:0] m_ax_r;
  logic signed [CW-1:0] m_ay_r;

  // Output stage: shift, apply signs, offset the contact and saturate.
  logic signed [CW+1:0] pen_x;
  logic signed [CW+1:0] pen_y;
  logic signed [CW+1:0] con_x;
  logic signed [CW+1:0] con_y;
  logic signed [NW-1:0] nrm_x;
  logic signed [NW-1:0] nrm_y;
  out_t                 res;

  always_comb begin
    pen_x = (CW+2)'(m_px_r[DW+QW-1:NFB]);
    pen_y = (CW+2)'(m_py_r[DW+QW-1:NFB]);
    con_x = (CW+2)'(m_cx_r[RW+QW-1:NFB]);
    con_y = (CW+2)'(m_cy_r[RW+QW-1:NFB]);
    nrm_x = NW'(m_nx_r);
    nrm_y = NW'(m_ny_r);
    if (m_sx_r) begin
      pen_x = -pen_x;
      con_x = -con_x;
      nrm_x = -nrm_x;
    end
    if (m_sy_r) begin
      pen_y = -pen_y;
      con_y = -con_y;
      nrm_y = -nrm_y;
    end
    con_x = con_x + (CW+2)'(m_ax_r);
    con_y = con_y + (CW+2)'(m_ay_r);
    res   = '0;
    if (m_hit_r) begin
      res.hit       = 1'b1;
      res.normal_x  = nrm_x;
      res.normal_y  = nrm_y;
      res.overlap_x = sat_coord(pen_x);
      res.overlap_y = sat_coord(pen_y);
      res.contact_x = sat_coord(con_x);
      res.contact_y = sat_coord(con_y);
    end
  end

  logic out_valid_r;
  out_t out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m_vld_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      m_vld_r     <= dv_vld[QW];
      out_valid_r <= m_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      m_hit_r    <= sd_end.hit;
      m_sx_r     <= sd_end.sx;
      m_sy_r     <= sd_end.sy;
      m_nx_r     <= nmx;
      m_ny_r     <= nmy;
      m_px_r     <= pen_m * nmx;
      m_py_r     <= pen_m * nmy;
      m_cx_r     <= con_m * nmx;
      m_cy_r     <= con_m * nmy;
      m_ax_r     <= sd_end.ax;
      m_ay_r     <= sd_end.ay;
      out_data_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
endmodule

>>> rtl/cpcm_checker.sv
// ----------------------------------------------------------------------------
// Circle pair contact manifold checker
// Port-level checks on the contact manifold block, bound to the top level.
// ----------------------------------------------------------------------------
`include "circle_pair_contact_manifold_macros.svh"

module cpcm_checker (
  input logic           clk,
  input logic           rst_n,
  input logic           in_valid,
  input logic           in_stall,
  input cpcm_pkg::in_t  in_data,
  input logic           out_valid,
  input logic           out_stall,
  input cpcm_pkg::out_t out_data
);
  import cpcm_pkg::*;

  // The input side only backs up when a finished word is held at the output.
  `CPCM_ASSERT_IMPL(a_stall_cause, in_stall, out_valid && out_stall)

  // A stalled input word stays offered and unchanged.
  `CPCM_ASSERT_NEXT(a_in_hold, in_valid && in_stall, in_valid && $stable(in_data))

  // A held result word stays put.
  `CPCM_ASSERT_NEXT(a_out_hold, out_valid && out_stall,
                    out_valid && $stable(out_data))

  // A miss carries nothing but zeros.
  `CPCM_ASSERT_IMPL(a_miss_zero, out_valid && !out_data.hit,
                    out_data.normal_x == '0 && out_data.normal_y == '0 &&
                    out_data.overlap_x == '0 && out_data.overlap_y == '0 &&
                    out_data.contact_x == '0 && out_data.contact_y == '0)

  // The normal never exceeds unit length in either component.
  `CPCM_ASSERT_IMPL(a_normal_range, out_valid,
                    out_data.normal_x <= 16'sd16384 && out_data.normal_x >= -16'sd16384 &&
                    out_data.normal_y <= 16'sd16384 && out_data.normal_y >= -16'sd16384)
endmodule

bind circle_pair_contact_manifold cpcm_checker u_cpcm_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
